### rtl/core/lfr_pkg.sv
// shared types, constants and seeding function of the lagged fibonacci range generator
package lfr_pkg;

   localparam int unsigned RING_LEN   = 55;
   localparam int unsigned LAG_OFFSET = 31;
   localparam int unsigned WORD_BITS  = 30;
   localparam int unsigned VAL_BITS   = 16;
   localparam int unsigned SEED_WORDS = 10;
   localparam int unsigned IDX_BITS   = $clog2(RING_LEN);

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [VAL_BITS-1:0]  val_type;

   localparam logic OP_RAW   = 1'b0;
   localparam logic OP_RANGE = 1'b1;

   localparam word_type RESET_SEED = word_type'(1);

   typedef struct packed {
      logic                       op;
      logic signed [VAL_BITS-1:0] range_low;
      logic signed [VAL_BITS-1:0] range_high;
   } req_type;

   typedef struct packed {
      word_type                   raw_word;
      logic signed [VAL_BITS-1:0] ranged_value;
   } rsp_type;

   // decoded range request: draws are needed only for a span above one
   typedef struct packed {
      logic    draw_needed;
      val_type limit;        // span minus one, largest accepted masked value
      val_type mask;
   } span_info_type;

   // seeded ring word k is a*seed + b with fibonacci coefficients
   function automatic word_type seed_word(input logic [IDX_BITS-1:0] idx,
                                          input word_type seed);
      logic [5:0] coef_a;
      logic [5:0] coef_b;
      begin
         case (idx)
            6'd0: begin coef_a = 6'd1;  coef_b = 6'd0;  end
            6'd1: begin coef_a = 6'd0;  coef_b = 6'd1;  end
            6'd2: begin coef_a = 6'd1;  coef_b = 6'd1;  end
            6'd3: begin coef_a = 6'd1;  coef_b = 6'd2;  end
            6'd4: begin coef_a = 6'd2;  coef_b = 6'd3;  end
            6'd5: begin coef_a = 6'd3;  coef_b = 6'd5;  end
            6'd6: begin coef_a = 6'd5;  coef_b = 6'd8;  end
            6'd7: begin coef_a = 6'd8;  coef_b = 6'd13; end
            6'd8: begin coef_a = 6'd13; coef_b = 6'd21; end
            6'd9: begin coef_a = 6'd21; coef_b = 6'd34; end
            default: begin coef_a = 6'd0; coef_b = 6'd0; end
         endcase
         seed_word = word_type'(word_type'(coef_a) * seed + word_type'(coef_b));
      end
   endfunction

endpackage

### rtl/core/lfr_cell.sv
// one ring cell: holds a word, reloads on seeding, takes its neighbor's word on a draw
module lfr_cell (
   input  logic              clock,
   input  logic              load_en,
   input  lfr_pkg::word_type load_word,
   input  logic              shift_en,
   input  lfr_pkg::word_type shift_word,
   output lfr_pkg::word_type word_out
);

   lfr_pkg::word_type word_ff;
   lfr_pkg::word_type word_in;

   always_comb begin
      word_in = word_ff;
      if (load_en) begin
         word_in = load_word;
      end else if (shift_en) begin
         word_in = shift_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;

endmodule

### rtl/core/lfr_span.sv
// decodes a range request into draw need, acceptance limit and draw mask
module lfr_span (
   input  lfr_pkg::req_type       req,
   output lfr_pkg::span_info_type info
);

   logic signed [lfr_pkg::VAL_BITS:0] diff;
   lfr_pkg::val_type                   smear;

   always_comb begin
      diff = {req.range_high[lfr_pkg::VAL_BITS-1], req.range_high}
           - {req.range_low[lfr_pkg::VAL_BITS-1], req.range_low};
      // fill every bit below the top set bit of the limit
      smear = diff[lfr_pkg::VAL_BITS-1:0];
      smear = smear | (smear >> 1);
      smear = smear | (smear >> 2);
      smear = smear | (smear >> 4);
      smear = smear | (smear >> 8);
      info.draw_needed = !diff[lfr_pkg::VAL_BITS] && (|diff[lfr_pkg::VAL_BITS-1:0]);
      info.limit       = diff[lfr_pkg::VAL_BITS-1:0];
      info.mask        = smear;
   end

endmodule

### rtl/core/lagged_fibonacci_range_rng_core.sv
// top level of the additive lagged fibonacci generator with ranged draws
// a word is taken, then the draws are made in ST_RUN (none when no draw is needed)
// before the result is registered on rsp_; rsp_valid rises the cycle after the last draw
// a new word is taken only in ST_IDLE with the output slot free or being emptied;
// the ring shifts one cell per draw, so draws of one word are strictly sequential
// reset (synchronous): ring reloads with seed 1, output empty, no clearing pass
module lagged_fibonacci_range_rng_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lfr_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lfr_pkg::rsp_type  rsp_data,
   input  logic              csr_wr_en,
   input  lfr_pkg::word_type csr_wr_data
);

   // one-hot sequencer states
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   // ring cells: cell 0 and cell LAG_OFFSET are the lagged pair, the last cell the write position
   lfr_pkg::word_type ring_word [lfr_pkg::RING_LEN];
   lfr_pkg::word_type draw_sum;
   lfr_pkg::word_type seed_src;
   logic              seed_load;
   logic              shift_en;

   // latched request
   logic                  op_ff;
   logic                  op_in;
   lfr_pkg::val_type      low_ff;
   lfr_pkg::val_type      low_in;
   lfr_pkg::span_info_type info_ff;
   lfr_pkg::span_info_type info_in;
   lfr_pkg::span_info_type req_info;
   logic                  draws_ff;
   logic                  draws_in;

   // output register
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   lfr_pkg::rsp_type rsp_data_ff;
   lfr_pkg::rsp_type rsp_data_in;

   logic             req_take;
   logic             item_done;
   logic             draw_hit;
   lfr_pkg::val_type masked;

   // seeding happens on reset and on every seed write
   assign seed_load = reset || csr_wr_en;
   assign seed_src  = reset ? lfr_pkg::RESET_SEED : csr_wr_data;

   // the additive step: sum of the two lagged words enters at the tail
   assign draw_sum = ring_word[0] + ring_word[lfr_pkg::LAG_OFFSET];

   for (genvar gi = 0; gi < lfr_pkg::RING_LEN; gi++) begin : g_ring
      lfr_pkg::word_type cell_load;
      lfr_pkg::word_type cell_next;

      if (gi < lfr_pkg::SEED_WORDS) begin : g_seeded
         assign cell_load = lfr_pkg::seed_word(lfr_pkg::IDX_BITS'(gi), seed_src);
      end else begin : g_zero
         assign cell_load = '0;
      end

      // each cell takes its upper neighbor; the last cell takes the new sum
      if (gi == lfr_pkg::RING_LEN - 1) begin : g_tail
         assign cell_next = draw_sum;
      end else begin : g_body
         assign cell_next = ring_word[gi+1];
      end

      lfr_cell u_cell (
         .clock      (clock),
         .load_en    (seed_load),
         .load_word  (cell_load),
         .shift_en   (shift_en),
         .shift_word (cell_next),
         .word_out   (ring_word[gi])
      );
   end

   lfr_span u_span (
      .req  (req_data),
      .info (req_info)
   );

   // a new word only when idle and the output slot is free or being emptied
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_take  = req_valid && req_ready;

   // masked draw and rejection test
   assign masked   = draw_sum[lfr_pkg::VAL_BITS-1:0] & info_ff.mask;
   assign draw_hit = (op_ff == lfr_pkg::OP_RAW) || (masked <= info_ff.limit);

   assign shift_en  = (state_ff == ST_RUN) && draws_ff && !seed_load;
   assign item_done = (state_ff == ST_RUN) && (!draws_ff || draw_hit);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (item_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      op_in    = op_ff;
      low_in   = low_ff;
      info_in  = info_ff;
      draws_in = draws_ff;
      if (req_take) begin
         op_in    = req_data.op;
         low_in   = req_data.range_low;
         info_in  = req_info;
         draws_in = (req_data.op == lfr_pkg::OP_RAW) || req_info.draw_needed;
      end
   end

   // result: the slot is always empty when an item finishes
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (item_done) begin
         rsp_valid_in = 1'b1;
         if (!draws_ff) begin
            // empty or single-value range: no draw, return the low bound
            rsp_data_in.raw_word     = '0;
            rsp_data_in.ranged_value = low_ff;
         end else if (op_ff == lfr_pkg::OP_RAW) begin
            rsp_data_in.raw_word     = draw_sum;
            rsp_data_in.ranged_value = '0;
         end else begin
            rsp_data_in.raw_word     = draw_sum;
            rsp_data_in.ranged_value = low_ff + masked;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         draws_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         draws_ff     <= draws_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      low_ff      <= low_in;
      info_ff     <= info_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
